// File: rtl/mmh_pkg.sv
`timescale 1ns / 1ps

package mmh_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 32;
  localparam int unsigned WORD_BITS       = 64;
  localparam int unsigned LEN_IN_BITS     = 32;
  localparam int unsigned IN_DATA_BITS    = 160;
  localparam int unsigned BUF_WORDS       = 8;
  localparam int unsigned REM_BITS        = 7;   // bytes left in the last chunk, 0..64
  localparam int unsigned POS_BITS        = 6;   // byte offset inside the chunk buffer

  localparam logic [63:0] SALT0 = 64'h243F6A8885A308D3;
  localparam logic [63:0] SALT1 = 64'h13198A2E03707344;
  localparam logic [63:0] SALT2 = 64'hA4093822299F31D0;
  localparam logic [63:0] SALT3 = 64'h082EFA98EC4E6C89;
  localparam logic [63:0] SALT4 = 64'h452821E638D01377;

  // operand selection for the shared multiply-mix unit
  typedef enum logic [1:0] {
    MIX_FOLD  = 2'd0,
    MIX_ROUND = 2'd1,
    MIX_TAIL  = 2'd2,
    MIX_FINAL = 2'd3
  } mix_op_t;

  typedef struct packed {
    logic    accept;
    logic    store;
    logic    mix_start;
    logic    mix_apply;
    mix_op_t mix_op;
    logic [1:0] fold_idx;
    logic    fin_init;
    logic    tail_load;
    logic    out_write;
  } mmh_cmd_t;

  typedef struct packed {
    logic fold_need;
    logic more_rounds;
    logic last;
    logic mix_done;
    logic out_busy;
  } mmh_status_t;

endpackage

// File: rtl/mmh_mix.sv
`timescale 1ns / 1ps

module mmh_mix
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  input  logic [63:0] y,
  output logic        done,
  output logic [63:0] result
);

  logic [63:0]  xr;
  logic [63:0]  yr;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         busy;
  logic [31:0]  xa;
  logic [31:0]  yb;
  logic [63:0]  pp;
  logic [1:0]   sh;
  logic [127:0] addend;

  // one 32x32 partial product per cycle, x half by cnt[0], y half by cnt[1]
  assign xa = cnt[0] ? xr[63:32] : xr[31:0];
  assign yb = cnt[1] ? yr[63:32] : yr[31:0];
  assign pp = 64'(xa) * 64'(yb);
  assign sh = 2'({1'b0, cnt[0]} + {1'b0, cnt[1]});

  always_comb begin
    case (sh)
      2'd0:    addend = {64'd0, pp};
      2'd1:    addend = {32'd0, pp, 32'd0};
      2'd2:    addend = {pp, 64'd0};
      default: addend = 128'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr  <= x;
      yr  <= y;
      acc <= 128'd0;
    end else if (busy) begin
      acc <= acc + addend;
    end
  end

  assign result = acc[63:0] ^ acc[127:64];

endmodule

// File: rtl/mmh_datapath.sv
`timescale 1ns / 1ps

module mmh_datapath
  import mmh_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mmh_cmd_t                cmd,
  output mmh_status_t             status,
  input  logic [IN_DATA_BITS-1:0] in_data,
  input  logic                    in_last,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [WORD_BITS-1:0]    out_data
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  logic [63:0]             main_lane;
  logic [63:0]             second_lane;
  logic [63:0]             chunk_buffer [BUF_WORDS];
  logic [LENGTH_BITS-1:0]  bytes_taken;
  logic [LENGTH_BITS-1:0]  message_length;
  logic                    in_message;
  logic [63:0]             word_q;
  logic                    last_q;
  logic [63:0]             fold_main;
  logic [63:0]             fold_second;
  logic [63:0]             state_q;
  logic [POS_BITS-1:0]     pos;
  logic [REM_BITS-1:0]     rem;
  logic [LENGTH_BITS-1:0]  len_q;
  logic [63:0]             tail_a;
  logic [63:0]             tail_b;
  logic [63:0]             mid_q;
  logic [63:0]             hash_q;

  logic [63:0]             seed_in;
  logic [63:0]             tlen64;
  logic [LENGTH_BITS-1:0]  len_sat;
  logic [LENGTH_BITS-1:0]  taken_next;
  logic [LENGTH_BITS-1:0]  fin_len;
  logic [LENGTH_BITS-1:0]  fin_base;
  logic [LENGTH_BITS-1:0]  fin_rem;
  logic [511:0]            flat;
  logic [63:0]             mix_x;
  logic [63:0]             mix_y;
  logic [63:0]             mix_res;
  logic                    mix_done;
  logic [63:0]             tail_a_next;
  logic [63:0]             tail_b_next;
  logic [POS_BITS-1:0]     rem6;
  logic [2:0]              fidx_even;
  logic [2:0]              fidx_odd;
  logic [2:0]              ridx;
  logic [63:0]             fold_salt;

  function automatic logic [7:0] get_byte(input logic [511:0] f, input logic [POS_BITS-1:0] i);
    get_byte = f[{i, 3'b000} +: 8];
  endfunction

  function automatic logic [63:0] load8(input logic [511:0] f, input logic [POS_BITS-1:0] s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) begin
      v[8*i +: 8] = get_byte(f, POS_BITS'(s + POS_BITS'(i)));
    end
    load8 = v;
  endfunction

  function automatic logic [63:0] load4(input logic [511:0] f, input logic [POS_BITS-1:0] s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < 4; i++) begin
      v[8*i +: 8] = get_byte(f, POS_BITS'(s + POS_BITS'(i)));
    end
    load4 = v;
  endfunction

  assign seed_in    = in_data[63:0];
  assign tlen64     = 64'(in_data[95:64]);
  assign len_sat    = (tlen64 > 64'(LEN_MAX)) ? LEN_MAX : LENGTH_BITS'(tlen64);
  assign taken_next = ((LEN_MAX - bytes_taken) < LENGTH_BITS'(8)) ? LEN_MAX
                    : bytes_taken + LENGTH_BITS'(8);

  assign fin_len  = (message_length < bytes_taken) ? message_length : bytes_taken;
  assign fin_base = (bytes_taken == '0) ? '0
                  : ((bytes_taken - LENGTH_BITS'(1)) & ~LENGTH_BITS'(63));
  assign fin_rem  = fin_len - ((fin_len > fin_base) ? fin_base : fin_len);

  always_comb begin
    for (int i = 0; i < BUF_WORDS; i++) begin
      flat[64*i +: 64] = chunk_buffer[i];
    end
  end

  // operand selection for the shared mix unit
  assign fidx_even = {cmd.fold_idx, 1'b0};
  assign fidx_odd  = {cmd.fold_idx, 1'b1};
  assign ridx      = pos[5:3];

  always_comb begin
    case (cmd.fold_idx)
      2'd0:    fold_salt = SALT1;
      2'd1:    fold_salt = SALT2;
      2'd2:    fold_salt = SALT3;
      default: fold_salt = SALT4;
    endcase
  end

  always_comb begin
    case (cmd.mix_op)
      MIX_FOLD: begin
        mix_x = chunk_buffer[fidx_even] ^ fold_salt;
        mix_y = chunk_buffer[fidx_odd] ^ (cmd.fold_idx[1] ? second_lane : main_lane);
      end
      MIX_ROUND: begin
        mix_x = chunk_buffer[ridx] ^ SALT1;
        mix_y = chunk_buffer[3'(ridx + 3'd1)] ^ state_q;
      end
      MIX_TAIL: begin
        mix_x = tail_a ^ SALT1;
        mix_y = tail_b ^ state_q;
      end
      default: begin
        mix_x = mid_q;
        mix_y = SALT1 ^ 64'(len_q);
      end
    endcase
  end

  mmh_mix u_mix (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mix_start),
    .x      (mix_x),
    .y      (mix_y),
    .done   (mix_done),
    .result (mix_res)
  );

  // overlapping tail loads, 0..16 bytes at pos
  assign rem6 = rem[POS_BITS-1:0];
  always_comb begin
    tail_a_next = '0;
    tail_b_next = '0;
    if (rem > REM_BITS'(8)) begin
      tail_a_next = load8(flat, pos);
      tail_b_next = load8(flat, POS_BITS'(pos + rem6 - POS_BITS'(8)));
    end else if (rem > REM_BITS'(3)) begin
      tail_a_next = load4(flat, pos);
      tail_b_next = load4(flat, POS_BITS'(pos + rem6 - POS_BITS'(4)));
    end else if (rem != '0) begin
      tail_a_next = {40'd0, get_byte(flat, pos),
                     get_byte(flat, POS_BITS'(pos + (rem6 >> 1))),
                     get_byte(flat, POS_BITS'(pos + rem6 - POS_BITS'(1)))};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_lane      <= '0;
      second_lane    <= '0;
      bytes_taken    <= '0;
      message_length <= '0;
      in_message     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.accept && !in_message) begin
        main_lane      <= seed_in ^ SALT0;
        second_lane    <= seed_in ^ SALT0;
        bytes_taken    <= '0;
        message_length <= len_sat;
        in_message     <= 1'b1;
      end
      if (cmd.mix_apply && cmd.mix_op == MIX_FOLD && cmd.fold_idx == 2'd3) begin
        main_lane   <= fold_main;
        second_lane <= fold_second ^ mix_res;
      end
      if (cmd.store && bytes_taken < message_length) begin
        bytes_taken <= taken_next;
      end
      if (cmd.out_write) begin
        out_valid  <= 1'b1;
        in_message <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word_q <= in_data[159:96];
      last_q <= in_last;
    end
    if (cmd.store && bytes_taken < message_length) begin
      chunk_buffer[bytes_taken[5:3]] <= word_q;
    end
    if (cmd.mix_apply) begin
      case (cmd.mix_op)
        MIX_FOLD: begin
          case (cmd.fold_idx)
            2'd0:    fold_main   <= mix_res;
            2'd1:    fold_main   <= fold_main ^ mix_res;
            2'd2:    fold_second <= mix_res;
            default: fold_second <= fold_second;
          endcase
        end
        MIX_ROUND: begin
          state_q <= mix_res;
          pos     <= POS_BITS'(pos + POS_BITS'(16));
          rem     <= REM_BITS'(rem - REM_BITS'(16));
        end
        MIX_TAIL: mid_q  <= mix_res;
        default:  hash_q <= mix_res;
      endcase
    end
    if (cmd.fin_init) begin
      len_q   <= fin_len;
      state_q <= (fin_len > LENGTH_BITS'(64)) ? (main_lane ^ second_lane) : main_lane;
      pos     <= '0;
      rem     <= REM_BITS'(fin_rem);
    end
    if (cmd.tail_load) begin
      tail_a <= tail_a_next;
      tail_b <= tail_b_next;
    end
    if (cmd.out_write) begin
      out_data <= hash_q;
    end
  end

  assign status.fold_need   = (bytes_taken < message_length) && (bytes_taken != '0)
                            && (bytes_taken[5:0] == 6'd0);
  assign status.more_rounds = rem > REM_BITS'(16);
  assign status.last        = last_q;
  assign status.mix_done    = mix_done;
  assign status.out_busy    = out_valid && !out_ready;

endmodule

// File: rtl/mmh_ctrl.sv
`timescale 1ns / 1ps

module mmh_ctrl
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  mmh_status_t status,
  output mmh_cmd_t    cmd
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CHECK = 10'b0000000010,
    ST_FOLD  = 10'b0000000100,
    ST_STORE = 10'b0000001000,
    ST_FINIT = 10'b0000010000,
    ST_ROUND = 10'b0000100000,
    ST_TAIL  = 10'b0001000000,
    ST_MIX1  = 10'b0010000000,
    ST_MIX2  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic       issued;
  logic       issued_next;
  logic [1:0] fold_k;
  logic [1:0] fold_k_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    issued_next  = issued;
    fold_k_next  = fold_k;
    cmd          = '0;
    cmd.mix_op   = MIX_FOLD;
    cmd.fold_idx = fold_k;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        fold_k_next = 2'd0;
        state_next  = status.fold_need ? ST_FOLD : ST_STORE;
      end
      ST_FOLD: begin
        cmd.mix_op = MIX_FOLD;
        if (!issued) begin
          cmd.mix_start = 1'b1;
          issued_next   = 1'b1;
        end else if (status.mix_done) begin
          cmd.mix_apply = 1'b1;
          issued_next   = 1'b0;
          fold_k_next   = 2'(fold_k + 2'd1);
          if (fold_k == 2'd3) begin
            state_next = ST_STORE;
          end
        end
      end
      ST_STORE: begin
        cmd.store  = 1'b1;
        state_next = status.last ? ST_FINIT : ST_IDLE;
      end
      ST_FINIT: begin
        cmd.fin_init = 1'b1;
        state_next   = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.mix_op = MIX_ROUND;
        if (!issued) begin
          if (status.more_rounds) begin
            cmd.mix_start = 1'b1;
            issued_next   = 1'b1;
          end else begin
            state_next = ST_TAIL;
          end
        end else if (status.mix_done) begin
          cmd.mix_apply = 1'b1;
          issued_next   = 1'b0;
        end
      end
      ST_TAIL: begin
        cmd.tail_load = 1'b1;
        state_next    = ST_MIX1;
      end
      ST_MIX1: begin
        cmd.mix_op = MIX_TAIL;
        if (!issued) begin
          cmd.mix_start = 1'b1;
          issued_next   = 1'b1;
        end else if (status.mix_done) begin
          cmd.mix_apply = 1'b1;
          issued_next   = 1'b0;
          state_next    = ST_MIX2;
        end
      end
      ST_MIX2: begin
        cmd.mix_op = MIX_FINAL;
        if (!issued) begin
          cmd.mix_start = 1'b1;
          issued_next   = 1'b1;
        end else if (status.mix_done) begin
          cmd.mix_apply = 1'b1;
          issued_next   = 1'b0;
          state_next    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          cmd.out_write = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next  = ST_IDLE;
        issued_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
      fold_k <= 2'd0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
      fold_k <= fold_k_next;
    end
  end

endmodule

// File: rtl/multiply_mix_byte_hash64.sv
`timescale 1ns / 1ps

// streaming 64-bit multiply-mix hash of a byte message
// input channel s_axis: one word per 8 message bytes, little-endian; the first
//   word of a message also carries seed and total length, tlast marks the final
//   word (an empty message is a single word with tlast set)
// output channel m_axis: one 64-bit hash word per message, after the final word
// mixing: one shared mix unit (four 32x32 partial products per mix) does all
//   multiplies; a word that opens a new 64-byte chunk first waits while four
//   mixes fold the previous chunk into the lanes
// after the final word: up to three 16-byte rounds and two closing mixes run
//   before the hash word is offered, and that fold comes first when that word
//   opens a new chunk
// one word is in flight at a time: s_axis_tready is high only in the idle state
// the hash word sits in an output register; while the receiver stalls the next
//   message is already taken in, and only its own result waits for the register
// reset (rst, synchronous) clears the lanes, counters and the output valid;
//   the chunk buffer needs no clearing, bytes past the length are never read
// lengths above 2^LENGTH_BITS-1 saturate there
module multiply_mix_byte_hash64
  import mmh_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_DATA_BITS-1:0] s_axis_tdata,  // seed[63:0], total_length[95:64], data_word[159:96]
  input  logic                    s_axis_tlast,  // last_word
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [WORD_BITS-1:0]    m_axis_tdata   // hash_value[63:0]
);

  mmh_cmd_t    cmd;
  mmh_status_t status;

  mmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mmh_datapath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: rtl/mmh_checker.sv
`timescale 1ns / 1ps

module mmh_checker
  import mmh_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [WORD_BITS-1:0] m_axis_tdata
);

  // a stalled hash word holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("hash word dropped or changed under stall");

  // reset leaves no hash word pending
  assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid after reset");

  // one word in flight: no second accept right after one
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous word in flight");

  // a hash word never appears the cycle after an accept
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("hash word too early");

endmodule

bind multiply_mix_byte_hash64 mmh_checker u_mmh_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
